// ===== design/srt_pkg.sv =====
// Shared types, constants and helpers for the server registry table.
// No dependencies; all design files but srt_ram refer to it by scoped names.
package srt_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 64;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int CFG_W       = 7;
  localparam int LIM_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;
  localparam logic [6:0]       LOAD_MAX    = 7'd100;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_SLOTS_IN_USE = 1'b0;

  // Action codes; codes above ACT_SET_LOAD are ignored
  typedef enum logic [2:0] {
    ACT_REGISTER      = 3'd0,
    ACT_UPDATE_LOAD   = 3'd1,
    ACT_UNREGISTER    = 3'd2,
    ACT_RESET_METRICS = 3'd3,
    ACT_SET_STAGE     = 3'd4,
    ACT_SET_LOAD      = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STAT_EXISTING  = 2'd0,
    STAT_INSERTED  = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DATA_RD,
    ST_WRITE
  } state_t;

  // Input beat
  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] host_key;
    logic [15:0] port_number;
    logic [31:0] free_space_mb;
    logic [7:0]  utilization;
    logic [7:0]  machine_load;
    logic        stage_on;
    logic [31:0] now_ms;
  } item_t;

  // Result beat
  typedef struct packed {
    status_t     status;
    logic [5:0]  slot_index;
    logic [31:0] full_drops;
  } result_t;

  // Key memory word
  typedef struct packed {
    logic [63:0] host;
    logic [15:0] port;
  } slot_key_t;

  // Data memory word
  typedef struct packed {
    logic [31:0] free_space;
    logic [7:0]  utilization;
    logic [31:0] seen_ms;
    logic [31:0] fault_state;
    logic [6:0]  load;
    logic        stage;
  } slot_data_t;

  // Active slot count: the configured value, capped at the table size
  function automatic logic [CNT_W-1:0] clamp_limit(logic [CFG_W-1:0] v);
    logic [LIM_W-1:0] wide;
    wide = LIM_W'(v);
    if (wide > LIM_W'(TABLE_SLOTS)) begin
      return CNT_W'(TABLE_SLOTS);
    end
    return CNT_W'(wide);
  endfunction

endpackage

// ===== design/srt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/srt_regs.sv =====
// APB-style configuration register block (slots_in_use).
// Depends on srt_pkg.
module srt_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srt_pkg::PADDR_W-1:0]   paddr,
  input  logic [srt_pkg::PDATA_W-1:0]   pwdata,
  output logic [srt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [srt_pkg::CFG_W-1:0]     slots_in_use
);

  logic sel_slots;

  assign pready    = 1'b1;
  assign sel_slots = (paddr[srt_pkg::PADDR_W-1:2] == srt_pkg::REG_SLOTS_IN_USE);

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= srt_pkg::SLOTS_RESET;
    end else if (psel && penable && pwrite && sel_slots) begin
      slots_in_use <= pwdata[srt_pkg::CFG_W-1:0];
    end
  end

  // read back
  assign prdata = sel_slots ? srt_pkg::PDATA_W'(slots_in_use) : '0;

endmodule

// ===== design/srt_engine.sv =====
// Table engine: slot valid bits, key and data memories, and the
// scan / read-modify-write sequencer. Depends on srt_pkg and srt_ram.
module srt_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [srt_pkg::CFG_W-1:0] slots_in_use,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  srt_pkg::item_t            item,
  output logic                      res_valid,
  input  logic                      res_ready,
  output srt_pkg::result_t          res
);

  srt_pkg::state_t   state, state_next;
  srt_pkg::item_t    cur;
  logic [srt_pkg::CNT_W-1:0] lim;
  logic [srt_pkg::CNT_W-1:0] rd_addr;
  logic                      cmp_pend;
  logic [srt_pkg::IDX_W-1:0] cmp_idx;
  logic                      found;
  logic [srt_pkg::IDX_W-1:0] hit_idx;
  logic                      free_found;
  logic [srt_pkg::IDX_W-1:0] free_idx;
  logic [srt_pkg::TABLE_SLOTS-1:0] valid;
  logic [31:0]               drops;
  logic [31:0]               drops_next;

  srt_pkg::slot_key_t  key_rdata, key_wdata;
  srt_pkg::slot_data_t data_rdata, data_wdata;
  logic                key_we, data_we;
  logic [srt_pkg::IDX_W-1:0] data_waddr;

  logic accept, issue, hit_now, known, wr_fire, ins, full;
  logic [6:0] load_clamped;

  assign accept  = item_valid && item_ready;
  assign known   = item.action inside {[srt_pkg::ACT_REGISTER:srt_pkg::ACT_SET_LOAD]};
  assign issue   = (state == srt_pkg::ST_SCAN) && (rd_addr < lim) && !hit_now;
  assign hit_now = (state == srt_pkg::ST_SCAN) && cmp_pend && valid[cmp_idx] &&
                   (key_rdata.host == cur.host_key) && (key_rdata.port == cur.port_number);
  assign wr_fire = (state == srt_pkg::ST_WRITE) && res_ready;
  assign ins     = !found && free_found && (cur.action == srt_pkg::ACT_REGISTER);
  assign full    = !found && !free_found && (cur.action == srt_pkg::ACT_REGISTER);
  assign load_clamped = (cur.machine_load > {1'b0, srt_pkg::LOAD_MAX}) ?
                        srt_pkg::LOAD_MAX : cur.machine_load[6:0];

  // key memory: one slot read per scan cycle
  srt_ram #(
    .WIDTH ($bits(srt_pkg::slot_key_t)),
    .DEPTH (srt_pkg::TABLE_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (free_idx),
    .wdata (key_wdata),
    .raddr (rd_addr[srt_pkg::IDX_W-1:0]),
    .rdata (key_rdata)
  );

  // data memory: read at the hit slot, merged and written back (to the free slot on an insert)
  srt_ram #(
    .WIDTH ($bits(srt_pkg::slot_data_t)),
    .DEPTH (srt_pkg::TABLE_SLOTS)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (hit_idx),
    .rdata (data_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    res_valid  = 1'b0;
    case (state)
      srt_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_next = known ? srt_pkg::ST_SCAN : srt_pkg::ST_WRITE;
        end
      end
      srt_pkg::ST_SCAN: begin
        if (hit_now) begin
          state_next = srt_pkg::ST_DATA_RD;
        end else if (!issue && !cmp_pend) begin
          state_next = srt_pkg::ST_WRITE;
        end
      end
      srt_pkg::ST_DATA_RD: begin
        state_next = srt_pkg::ST_WRITE;
      end
      srt_pkg::ST_WRITE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = srt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srt_pkg::ST_IDLE;
      end
    endcase
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend   <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (accept) begin
      cmp_pend   <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (state == srt_pkg::ST_SCAN) begin
      cmp_pend <= issue;
      if (hit_now) begin
        found <= 1'b1;
      end
      if (cmp_pend && !valid[cmp_idx] && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  // scan payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur     <= item;
      lim     <= srt_pkg::clamp_limit(slots_in_use);
      rd_addr <= '0;
    end else if (state == srt_pkg::ST_SCAN) begin
      if (issue) begin
        rd_addr <= rd_addr + 1'b1;
        cmp_idx <= rd_addr[srt_pkg::IDX_W-1:0];
      end
      if (hit_now) begin
        hit_idx <= cmp_idx;
      end
      if (cmp_pend && !valid[cmp_idx] && !free_found) begin
        free_idx <= cmp_idx;
      end
    end
  end

  // merge of the entry written back
  always_comb begin
    data_wdata = data_rdata;
    key_wdata.host = cur.host_key;
    key_wdata.port = cur.port_number;
    if (ins) begin
      data_wdata.free_space  = cur.free_space_mb;
      data_wdata.utilization = cur.utilization;
      data_wdata.seen_ms     = cur.now_ms;
      data_wdata.fault_state = '0;
      data_wdata.load        = '0;
      data_wdata.stage       = 1'b0;
    end else begin
      case (cur.action)
        srt_pkg::ACT_REGISTER: begin
          data_wdata.free_space  = cur.free_space_mb;
          data_wdata.utilization = cur.utilization;
          data_wdata.seen_ms     = cur.now_ms;
          data_wdata.fault_state = '0;
        end
        srt_pkg::ACT_UPDATE_LOAD: begin
          data_wdata.free_space  = cur.free_space_mb;
          data_wdata.utilization = cur.utilization;
          data_wdata.seen_ms     = cur.now_ms;
        end
        srt_pkg::ACT_RESET_METRICS: begin
          data_wdata.free_space  = '0;
          data_wdata.utilization = '0;
          data_wdata.fault_state = '0;
          data_wdata.load        = '0;
          data_wdata.seen_ms     = cur.now_ms;
        end
        srt_pkg::ACT_SET_STAGE: begin
          data_wdata.stage = cur.stage_on;
        end
        srt_pkg::ACT_SET_LOAD: begin
          data_wdata.load = load_clamped;
        end
        default: begin
          data_wdata = data_rdata;
        end
      endcase
    end
  end

  assign key_we     = wr_fire && ins;
  assign data_we    = wr_fire && (ins || (found && (cur.action != srt_pkg::ACT_UNREGISTER)));
  assign data_waddr = ins ? free_idx : hit_idx;
  assign drops_next = full ? drops + 32'd1 : drops;

  // result beat
  always_comb begin
    res.full_drops = drops_next;
    if (found) begin
      res.status     = srt_pkg::STAT_EXISTING;
      res.slot_index = 6'(hit_idx);
    end else if (ins) begin
      res.status     = srt_pkg::STAT_INSERTED;
      res.slot_index = 6'(free_idx);
    end else if (full) begin
      res.status     = srt_pkg::STAT_FULL;
      res.slot_index = '0;
    end else begin
      res.status     = srt_pkg::STAT_NOT_FOUND;
      res.slot_index = '0;
    end
  end

  // valid bits and drop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      drops <= '0;
    end else if (wr_fire) begin
      drops <= drops_next;
      if (ins) begin
        valid[free_idx] <= 1'b1;
      end else if (found && (cur.action == srt_pkg::ACT_UNREGISTER)) begin
        valid[hit_idx] <= 1'b0;
      end
    end
  end

  // checks
  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    (wr_fire && ins) |-> !valid[free_idx])
    else $error("insert into a slot already in use");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == srt_pkg::ST_WRITE && found) |-> valid[hit_idx])
    else $error("matched slot is not valid");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != srt_pkg::ST_IDLE))
    else $error("accepted beat did not start work");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    issue |-> (rd_addr < lim))
    else $error("scan read past active limit");

  a_drops_hold: assert property (@(posedge clk) disable iff (rst)
    !(wr_fire && full) |=> (drops == $past(drops)))
    else $error("drop counter moved without a dropped register");

endmodule

// ===== design/server_registry_table.sv =====
// Server registry table: a table of server entries keyed by host key and
// port. Each input beat is one action and yields one result beat. An item
// that misses scans the active slots (lim = active slot count, at most
// the table size) before the write; one that matches slot k ends the scan
// there and reads its data word first, and an unknown action code skips
// the scan. The scan reads one key word per cycle from the key memory's
// single read port. One beat is in work at a time; a finished result
// waits in the output register while the next beat is taken. Slot valid
// bits are flip-flops cleared by reset, so no clearing pass follows reset.
// Depends on srt_pkg, srt_regs, srt_engine.
module server_registry_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srt_pkg::PADDR_W-1:0] paddr,
  input  logic [srt_pkg::PDATA_W-1:0] pwdata,
  output logic [srt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  srt_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output srt_pkg::result_t            result
);

  logic [srt_pkg::CFG_W-1:0] slots_in_use;
  logic                      res_valid;
  logic                      res_ready;
  srt_pkg::result_t          res;

  srt_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .slots_in_use (slots_in_use)
  );

  srt_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .slots_in_use (slots_in_use),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register: takes a new beat when empty or being drained
  assign res_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      result <= res;
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for server_registry_table: keeps a shadow of the
// slot table, predicts each result beat and checks it under random idling.
// Depends on srt_pkg and the server_registry_table RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  // Longest item is a full miss, which scans the whole table
  localparam int SETTLE_CYCLES = srt_pkg::TABLE_SLOTS + 8;
  localparam int MAX_PRINTS    = 40;

  // Shadow entry; fault state is never set here, so it stays zero and is omitted
  typedef struct packed {
    logic        valid;
    logic [63:0] host;
    logic [15:0] port;
    logic [31:0] free_mb;
    logic [7:0]  util;
    logic [31:0] seen;
    logic [6:0]  load;
    logic        stage;
  } entry_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [srt_pkg::PADDR_W-1:0]  paddr = '0;
  logic [srt_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [srt_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;
  logic                         item_valid = 1'b0;
  logic                         item_ready;
  srt_pkg::item_t               item = '0;
  logic                         result_valid;
  logic                         result_ready = 1'b0;
  srt_pkg::result_t             result;

  entry_t                       shadow_table [srt_pkg::TABLE_SLOTS];
  int unsigned                  active_slots;
  logic [31:0]                  drop_count;

  srt_pkg::item_t               pending_items [$];
  srt_pkg::result_t             expected_results [$];
  srt_pkg::slot_key_t           key_pool [$];

  bit                  quiet = 1'b0;
  bit                  in_taken = 1'b0;
  int                  send_gap = 0;
  int                  stall_left = 0;
  int                  mismatches = 0;
  int                  items_applied = 0;
  int                  results_seen = 0;
  int                  status_count [4] = '{default: 0};
  int                  cycles = 0;

  server_registry_table dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one action to the shadow table and return the result it yields
  function automatic srt_pkg::result_t apply_action(srt_pkg::item_t it);
    srt_pkg::result_t r;
    int      lim;
    int      hit;
    int      free_at;
    int      i;
    lim     = (active_slots > srt_pkg::TABLE_SLOTS) ? srt_pkg::TABLE_SLOTS
                                                    : int'(active_slots);
    hit     = -1;
    free_at = -1;
    r.status     = srt_pkg::STAT_NOT_FOUND;
    r.slot_index = '0;
    // Lowest match within the active limit; lowest free slot ahead of it
    for (i = 0; i < lim; i++) begin
      if (!shadow_table[i].valid) begin
        if (free_at < 0) free_at = i;
      end else if (shadow_table[i].host == it.host_key &&
                   shadow_table[i].port == it.port_number) begin
        hit = i;
        break;
      end
    end
    if (it.action == srt_pkg::ACT_REGISTER) begin
      if (hit >= 0) begin
        shadow_table[hit].free_mb = it.free_space_mb;
        shadow_table[hit].util    = it.utilization;
        shadow_table[hit].seen    = it.now_ms;
        r.status     = srt_pkg::STAT_EXISTING;
        r.slot_index = 6'(hit);
      end else if (free_at >= 0) begin
        shadow_table[free_at]         = '0;
        shadow_table[free_at].valid   = 1'b1;
        shadow_table[free_at].host    = it.host_key;
        shadow_table[free_at].port    = it.port_number;
        shadow_table[free_at].free_mb = it.free_space_mb;
        shadow_table[free_at].util    = it.utilization;
        shadow_table[free_at].seen    = it.now_ms;
        r.status     = srt_pkg::STAT_INSERTED;
        r.slot_index = 6'(free_at);
      end else begin
        drop_count = drop_count + 32'd1;
        r.status   = srt_pkg::STAT_FULL;
      end
    end else if (it.action <= srt_pkg::ACT_SET_LOAD && hit >= 0) begin
      r.status     = srt_pkg::STAT_EXISTING;
      r.slot_index = 6'(hit);
      case (it.action)
        srt_pkg::ACT_UPDATE_LOAD: begin
          shadow_table[hit].free_mb = it.free_space_mb;
          shadow_table[hit].util    = it.utilization;
          shadow_table[hit].seen    = it.now_ms;
        end
        srt_pkg::ACT_UNREGISTER: begin
          shadow_table[hit] = '0;
        end
        srt_pkg::ACT_RESET_METRICS: begin
          shadow_table[hit].free_mb = '0;
          shadow_table[hit].util    = '0;
          shadow_table[hit].load    = '0;
          shadow_table[hit].seen    = it.now_ms;
        end
        srt_pkg::ACT_SET_STAGE: begin
          shadow_table[hit].stage = it.stage_on;
        end
        default: begin
          shadow_table[hit].load = (it.machine_load > 8'(srt_pkg::LOAD_MAX)) ?
                                   srt_pkg::LOAD_MAX : it.machine_load[6:0];
        end
      endcase
    end
    r.full_drops = drop_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("tb: result %0d %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  // Directed beat: payload fields all ones or all zeros, machine load as given
  function automatic srt_pkg::item_t mk(logic [2:0] act, srt_pkg::slot_key_t k, bit ones,
                                        logic [7:0] mload);
    srt_pkg::item_t it;
    it.action        = act;
    it.host_key      = k.host;
    it.port_number   = k.port;
    it.free_space_mb = ones ? '1 : '0;
    it.utilization   = ones ? '1 : '0;
    it.machine_load  = mload;
    it.stage_on      = ones;
    it.now_ms        = ones ? '1 : '0;
    return it;
  endfunction

  // Random beat, mostly on pooled keys so that matches and fills happen
  function automatic srt_pkg::item_t make_item(int reg_pct);
    srt_pkg::item_t     it;
    srt_pkg::slot_key_t k;
    int                 roll;
    roll = $urandom_range(0, 99);
    if (roll < reg_pct) it.action = srt_pkg::ACT_REGISTER;
    else if (roll < 97)
      it.action = 3'($urandom_range(srt_pkg::ACT_UPDATE_LOAD, srt_pkg::ACT_SET_LOAD));
    else it.action = 3'(srt_pkg::ACT_SET_LOAD) + 3'($urandom_range(1, 2));
    if (key_pool.size() == 0 || $urandom_range(0, 9) == 0) k = {$urandom, $urandom, 16'($urandom)};
    else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    it.host_key      = k.host;
    it.port_number   = k.port;
    it.free_space_mb = $urandom;
    it.utilization   = 8'($urandom);
    case ($urandom_range(0, 5))
      0:       it.machine_load = 8'(srt_pkg::LOAD_MAX);
      1:       it.machine_load = 8'(srt_pkg::LOAD_MAX) + 8'd1;
      2:       it.machine_load = 8'(srt_pkg::LOAD_MAX) - 8'd1;
      default: it.machine_load = 8'($urandom);
    endcase
    it.stage_on = 1'($urandom);
    it.now_ms   = $urandom;
    return it;
  endfunction

  // Key pool with near-miss pairs: same host other port, or one host bit off
  task automatic build_pool(int n);
    srt_pkg::slot_key_t k;
    int                 i;
    key_pool.delete();
    for (i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) begin
        k = key_pool[$urandom_range(0, i - 1)];
        if ($urandom_range(0, 1) == 0) k.port = 16'($urandom);
        else k.host[$urandom_range(0, 63)] ^= 1'b1;
      end else begin
        k = {$urandom, $urandom, 16'($urandom)};
      end
      key_pool.push_back(k);
    end
  endtask

  // Wait until the block is idle with nothing owed
  task automatic drain();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [srt_pkg::PADDR_W-1:0] addr,
                           logic [srt_pkg::PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Change the slot limit once idle; upper data bits carry junk
  task automatic set_limit(logic [6:0] v);
    drain();
    write_reg({srt_pkg::REG_SLOTS_IN_USE, 2'b00}, {25'($urandom), v});
    active_slots = v;
  endtask

  task automatic run_phase(logic [6:0] lim, int n, int pool, int reg_pct);
    set_limit(lim);
    build_pool(pool);
    repeat (n) pending_items.push_back(make_item(reg_pct));
  endtask

  // Item driver: next beat after acceptance, with random send gaps
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || in_taken) begin
      if (send_gap > 0) begin
        item_valid <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 12);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure in bursts
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      result_ready <= 1'b0;
      stall_left   <= $urandom_range(0, 11);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    srt_pkg::result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= item_valid && item_ready;
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", 32'(result.status), '0);
        end else begin
          want = expected_results.pop_front();
          status_count[want.status]++;
          if (result.status !== want.status)
            report_mismatch("status", 32'(result.status), 32'(want.status));
          if (result.slot_index !== want.slot_index)
            report_mismatch("slot_index", 32'(result.slot_index), 32'(want.slot_index));
          if (result.full_drops !== want.full_drops)
            report_mismatch("full_drops", result.full_drops, want.full_drops);
        end
      end
      if (item_valid && item_ready) begin
        items_applied++;
        expected_results.push_back(apply_action(item));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    srt_pkg::slot_key_t ka;
    srt_pkg::slot_key_t kb;
    srt_pkg::slot_key_t kc;
    int                 i;
    for (i = 0; i < srt_pkg::TABLE_SLOTS; i++) shadow_table[i] = '0;
    drop_count   = '0;
    active_slots = srt_pkg::SLOTS_RESET;
    ka = {64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF};
    kb = '0;
    kc = {64'hFFFF_FFFF_FFFF_FFFF, 16'h0000};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every action, clamp edges, unknown codes, misses, reuse of a freed slot
    pending_items.push_back(mk(srt_pkg::ACT_REGISTER, ka, 1'b1, 8'hFF));
    pending_items.push_back(mk(srt_pkg::ACT_REGISTER, kb, 1'b0, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_REGISTER, ka, 1'b0, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_UPDATE_LOAD, kb, 1'b1, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_SET_LOAD, ka, 1'b1, 8'hFF));
    pending_items.push_back(mk(srt_pkg::ACT_SET_LOAD, ka, 1'b0, 8'(srt_pkg::LOAD_MAX)));
    pending_items.push_back(mk(srt_pkg::ACT_SET_LOAD, ka, 1'b0,
                               8'(srt_pkg::LOAD_MAX) + 8'd1));
    pending_items.push_back(mk(srt_pkg::ACT_SET_LOAD, kb, 1'b0, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_SET_STAGE, ka, 1'b1, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_SET_STAGE, ka, 1'b0, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_RESET_METRICS, kb, 1'b1, 8'h00));
    pending_items.push_back(mk(3'(srt_pkg::ACT_SET_LOAD) + 3'd1, ka, 1'b1, 8'hFF));
    pending_items.push_back(mk(3'(srt_pkg::ACT_SET_LOAD) + 3'd2, ka, 1'b1, 8'hFF));
    pending_items.push_back(mk(srt_pkg::ACT_UPDATE_LOAD, kc, 1'b1, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_UNREGISTER, kb, 1'b0, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_UNREGISTER, kb, 1'b0, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_REGISTER, kc, 1'b1, 8'h00));
    // One slot: ka visible, kc parked above the limit
    set_limit(7'd1);
    pending_items.push_back(mk(srt_pkg::ACT_REGISTER, ka, 1'b1, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_REGISTER, kc, 1'b0, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_SET_STAGE, kc, 1'b1, 8'h00));
    // No slots at all
    set_limit(7'd0);
    pending_items.push_back(mk(srt_pkg::ACT_REGISTER, ka, 1'b0, 8'h00));
    pending_items.push_back(mk(srt_pkg::ACT_UPDATE_LOAD, ka, 1'b1, 8'h00));
    // Above the table size clamps to the full table
    set_limit(7'h7F);
    pending_items.push_back(mk(srt_pkg::ACT_UPDATE_LOAD, kc, 1'b1, 8'h00));

    // Random phases across limits; small limits fill and drop often
    run_phase(7'd64, 300, 90, 65);
    run_phase(7'd8, 250, 14, 45);
    run_phase(7'd1, 80, 3, 45);
    run_phase(7'd2, 80, 4, 45);
    run_phase(7'd0, 40, 6, 40);
    run_phase(7'd100, 150, 40, 40);
    run_phase(7'd33, 150, 50, 50);
    // Closing stretch at full rate, no idling on either side
    drain();
    quiet = 1'b1;
    run_phase(7'd64, 150, 30, 40);
    drain();

    $display("tb: %0d actions over slot limits 0, 1, 2, 8, 33, 64 and above table size",
             items_applied);
    $display("tb: existing %0d, inserted %0d, not found %0d, full %0d, drops %0d",
             status_count[srt_pkg::STAT_EXISTING], status_count[srt_pkg::STAT_INSERTED],
             status_count[srt_pkg::STAT_NOT_FOUND], status_count[srt_pkg::STAT_FULL],
             drop_count);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
